/* hw/rtl/fifoms_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifoms_pkg
// Shared types and constants of the FIFO with membership search.
// ----------------------------------------------------------------------------
package fifoms_pkg;

  // Queue geometry
  localparam int unsigned Depth    = 64;
  localparam int unsigned KeyWidth = 64;
  localparam int unsigned IdxW     = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW     = $clog2(Depth + 1);

  // Fixed field widths of the channels
  localparam int unsigned OpW      = 2;
  localparam int unsigned KeyFieldW = 64;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned OccW     = 7;

  typedef enum logic [OpW-1:0] {
    OpPush = 2'd0,
    OpPop  = 2'd1,
    OpFind = 2'd2
  } opcode_e;

  typedef enum logic [StatusW-1:0] {
    StatusOk    = 2'd0,
    StatusEmpty = 2'd1,
    StatusFull  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    StIdle,
    StPopRd,
    StScan,
    StEmit
  } state_e;

  typedef logic [IdxW-1:0]     idx_t;
  typedef logic [CntW-1:0]     cnt_t;
  typedef logic [KeyWidth-1:0] key_t;

  // Write port of the entry store
  typedef struct packed {
    logic we;
    idx_t addr;
    key_t data;
  } store_wr_t;

  // One result beat
  typedef struct packed {
    logic [StatusW-1:0]   status;
    logic [KeyFieldW-1:0] popped_key;
    logic                 found;
    logic [OccW-1:0]      occupancy;
  } rsp_t;

  // Circular increment of a queue index
  function automatic idx_t next_idx(idx_t i);
    idx_t r;
    if (i == IdxW'(Depth - 1)) begin
      r = '0;
    end else begin
      r = i + idx_t'(1);
    end
    return r;
  endfunction

endpackage

/* hw/rtl/fifoms_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifoms_req_if / fifoms_rsp_if
// Valid/ready channels for operation requests and their results.
// ----------------------------------------------------------------------------
interface fifoms_req_if
  import fifoms_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [OpW-1:0]       opcode;
  logic [KeyFieldW-1:0] key;

  modport source (output valid, output opcode, output key, input ready);
  modport sink   (input valid, input opcode, input key, output ready);
endinterface

interface fifoms_rsp_if
  import fifoms_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [StatusW-1:0]   status;
  logic [KeyFieldW-1:0] popped_key;
  logic                 found;
  logic [OccW-1:0]      occupancy;

  modport source (output valid, output status, output popped_key, output found,
                  output occupancy, input ready);
  modport sink   (input valid, input status, input popped_key, input found,
                  input occupancy, output ready);
endinterface

/* hw/rtl/fifo_with_membership_search_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_with_membership_search_top
// Circular key FIFO with push, pop and a find that scans the queued entries.
// ----------------------------------------------------------------------------
// One operation is worked on at a time. A push, a no-op, or a pop or find on
// an empty queue goes from the idle state straight to the emit state; a pop
// first does one store read, and a find compares the queued entries: the scan
// reads the store one entry per cycle from head toward tail and stops at the
// first match or after the last queued entry. A finished result sits in an
// output register, so the next operation is taken while the previous result
// still waits for the sink.
module fifo_with_membership_search_top
  import fifoms_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  fifoms_req_if.sink        in_i,
  fifoms_rsp_if.source      out_o
);

  state_e    state_q, state_d;
  idx_t      head_q, head_d;
  idx_t      tail_q, tail_d;
  cnt_t      count_q, count_d;
  idx_t      ptr_q, ptr_d;
  cnt_t      left_q, left_d;
  key_t      key_q, key_d;
  rsp_t      res_q, res_d;
  rsp_t      out_q, out_d;
  logic      out_vld_q, out_vld_d;

  store_wr_t wr;
  idx_t      raddr;
  key_t      rdata;

  logic      in_fire;
  logic      out_free;
  logic      is_full;
  logic      is_empty;
  logic      hit;
  key_t      in_key;

  fifoms_store u_store (
    .clk_i   (clk_i),
    .wr_i    (wr),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign in_i.ready = (state_q == StIdle);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_free   = !out_vld_q || out_o.ready;
  assign is_full    = (count_q == CntW'(Depth));
  assign is_empty   = (count_q == '0);
  assign in_key     = in_i.key[KeyWidth-1:0];
  assign hit        = (rdata == key_q);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          if (in_i.opcode == OpPop && !is_empty) begin
            state_d = StPopRd;
          end else if (in_i.opcode == OpFind && !is_empty) begin
            state_d = StScan;
          end else begin
            state_d = StEmit;
          end
        end
      end
      StPopRd: state_d = StEmit;
      StScan: begin
        if (hit || left_q == cnt_t'(1)) begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Datapath and store access
  always_comb begin
    head_d    = head_q;
    tail_d    = tail_q;
    count_d   = count_q;
    ptr_d     = ptr_q;
    left_d    = left_q;
    key_d     = key_q;
    res_d     = res_q;
    out_d     = out_q;
    out_vld_d = out_vld_q && !out_o.ready;
    wr        = '{we: 1'b0, addr: tail_q, data: in_key};
    raddr     = head_q;

    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          res_d = '{status: StatusOk, popped_key: '0, found: 1'b0,
                    occupancy: OccW'(count_q)};
          case (in_i.opcode)
            OpPush: begin
              if (is_full) begin
                res_d.status = StatusFull;
              end else begin
                wr.we           = 1'b1;
                tail_d          = next_idx(tail_q);
                count_d         = count_q + cnt_t'(1);
                res_d.occupancy = OccW'(count_q + cnt_t'(1));
              end
            end
            OpPop: begin
              if (is_empty) begin
                res_d.status = StatusEmpty;
              end
            end
            OpFind: begin
              key_d  = in_key;
              ptr_d  = next_idx(head_q);
              left_d = count_q;
            end
            default: ;
          endcase
        end
      end
      StPopRd: begin
        res_d.popped_key = KeyFieldW'(rdata);
        res_d.occupancy  = OccW'(count_q - cnt_t'(1));
        head_d           = next_idx(head_q);
        count_d          = count_q - cnt_t'(1);
      end
      StScan: begin
        // compare the entry read last cycle, fetch the next one
        raddr  = ptr_q;
        ptr_d  = next_idx(ptr_q);
        left_d = left_q - cnt_t'(1);
        res_d.found = hit;
      end
      StEmit: begin
        if (out_free) begin
          out_d     = res_q;
          out_vld_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      head_q    <= '0;
      tail_q    <= '0;
      count_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      count_q   <= count_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload and scan registers
  always_ff @(posedge clk_i) begin
    ptr_q  <= ptr_d;
    left_q <= left_d;
    key_q  <= key_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.status     = out_q.status;
  assign out_o.popped_key = out_q.popped_key;
  assign out_o.found      = out_q.found;
  assign out_o.occupancy  = out_q.occupancy;

  // Occupancy never exceeds the depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("entry count above depth");

  // A scan always has at least one entry left to compare
  a_scan_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StScan) |-> (left_q != '0))
    else $error("scan running with nothing left");

  // A push into a full queue leaves the count untouched
  a_full_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_i.opcode == OpPush && is_full) |=> (count_q == CntW'(Depth)))
    else $error("push on full queue changed the count");

  // An empty-pop result reports an empty queue
  a_empty_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status == StatusEmpty) |-> (out_o.occupancy == '0))
    else $error("empty status with nonzero occupancy");

endmodule

/* hw/rtl/fifoms_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifoms_store
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fifoms_store
  import fifoms_pkg::*;
(
  input  logic      clk_i,
  input  store_wr_t wr_i,
  input  idx_t      raddr_i,
  output key_t      rdata_o
);

  key_t mem [Depth];
  key_t rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* tb/sv/fifo_with_membership_search_top_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_with_membership_search_top_test
// Self-checking bench for the key FIFO with membership search. A shadow queue
// predicts every result beat. Stimulus covers empty, full and wrapped queues,
// hit and miss finds, and unused opcodes. Both channels idle at random except in the last phase.
// ----------------------------------------------------------------------------
module fifo_with_membership_search_top_test
  import fifoms_pkg::*;
;

  localparam logic [OpW-1:0] OpUnused = 2'd3;

  typedef enum int {
    BiasFill,
    BiasDrain,
    BiasMixed
  } mix_bias_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  fifoms_req_if req_if ();
  fifoms_rsp_if rsp_if ();

  fifo_with_membership_search_top DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (rsp_if)
  );

  // Shadow copy of the queue
  key_t shadow_keys [Depth];
  idx_t shadow_head;
  idx_t shadow_tail;
  cnt_t shadow_count;

  rsp_t predicted_rsps [$];
  int   mismatch_count;
  int   sender_idle_pct;
  int   recv_stall_pct;

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic idx_t advance_idx(idx_t i);
    return (i == idx_t'(Depth - 1)) ? '0 : idx_t'(i + 1);
  endfunction

  // Apply one operation to the shadow queue and return the expected beat
  function automatic rsp_t apply_queue_op(logic [OpW-1:0] op, key_t key);
    rsp_t r;
    idx_t i;
    r = '0;
    case (op)
      OpPush: begin
        if (shadow_count >= cnt_t'(Depth)) begin
          r.status = StatusFull;
        end else begin
          shadow_keys[shadow_tail] = key;
          shadow_tail = advance_idx(shadow_tail);
          shadow_count++;
        end
      end
      OpPop: begin
        if (shadow_count == '0) begin
          r.status = StatusEmpty;
        end else begin
          r.popped_key = KeyFieldW'(shadow_keys[shadow_head]);
          shadow_head = advance_idx(shadow_head);
          shadow_count--;
        end
      end
      OpFind: begin
        i = shadow_head;
        for (int n = 0; n < int'(shadow_count); n++) begin
          if (shadow_keys[i] == key) begin
            r.found = 1'b1;
            break;
          end
          i = advance_idx(i);
        end
      end
      default: ;
    endcase
    r.occupancy = OccW'(shadow_count);
    return r;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // Result sink: random stalls
  always @(posedge clk_i) begin
    if (recv_stall_pct == 0) begin
      rsp_if.ready <= 1'b1;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Result checker: oldest prediction against each accepted beat
  always @(posedge clk_i) begin : result_check
    rsp_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (predicted_rsps.size() == 0) begin
        $display("%0t: result beat with none expected, actual status %0h key %0h",
                 $time, rsp_if.status, rsp_if.popped_key);
        mismatch_count++;
      end else begin
        want = predicted_rsps.pop_front();
        check_field("status", 64'(want.status), 64'(rsp_if.status));
        check_field("popped_key", 64'(want.popped_key), 64'(rsp_if.popped_key));
        check_field("found", 64'(want.found), 64'(rsp_if.found));
        check_field("occupancy", 64'(want.occupancy), 64'(rsp_if.occupancy));
      end
    end
  end

  // Send one operation beat; valid stays high into the next call unless it idles
  task automatic send_op(logic [OpW-1:0] op, key_t key);
    if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    req_if.valid  <= 1'b1;
    req_if.opcode <= op;
    req_if.key    <= KeyFieldW'(key);
    do @(posedge clk_i); while (!req_if.ready);
    predicted_rsps.push_back(apply_queue_op(op, key));
  endtask

  // Hold off the sender until every predicted beat has arrived
  task automatic drain_results();
    req_if.valid <= 1'b0;
    while (predicted_rsps.size() != 0) @(posedge clk_i);
  endtask

  function automatic key_t rand_key();
    key_t k;
    case ($urandom_range(0, 5))
      0:       k = '0;
      1:       k = '1;
      2, 3:    k = key_t'({$urandom, $urandom});
      default: k = key_t'($urandom_range(0, 15));
    endcase
    return k;
  endfunction

  // Half of the time a key that is currently queued
  function automatic key_t find_key();
    int unsigned off;
    if (shadow_count != '0 && $urandom_range(1) == 0) begin
      off = $urandom_range(0, int'(shadow_count) - 1);
      return shadow_keys[idx_t'((shadow_head + off) % Depth)];
    end
    return rand_key();
  endfunction

  function automatic logic [OpW-1:0] pick_op(mix_bias_e bias);
    int unsigned r;
    int unsigned push_lim;
    int unsigned pop_lim;
    r = $urandom_range(99);
    case (bias)
      BiasFill:  begin push_lim = 65; pop_lim = 75; end
      BiasDrain: begin push_lim = 15; pop_lim = 75; end
      default:   begin push_lim = 35; pop_lim = 65; end
    endcase
    if (r < push_lim) return OpPush;
    if (r < pop_lim) return OpPop;
    if (r < 95) return OpFind;
    return OpUnused;
  endfunction

  // Extremes of the key, every opcode, empty-queue cases
  task automatic test_directed();
    send_op(OpPop, '1);
    send_op(OpFind, '0);
    send_op(OpUnused, '1);
    send_op(OpPush, '0);
    send_op(OpPush, '1);
    send_op(OpPush, 64'h8000_0000_0000_0001);
    send_op(OpFind, '1);
    send_op(OpFind, 64'h1);
    send_op(OpFind, '0);
    send_op(OpUnused, '0);
    send_op(OpPop, 64'h5555_5555_5555_5555);
    send_op(OpPop, 64'hAAAA_AAAA_AAAA_AAAA);
    send_op(OpPop, '0);
    send_op(OpPop, '0);
    send_op(OpFind, '1);
  endtask

  // Fill to full, push on full, wrap the indexes, search across the wrap
  task automatic test_fill_and_wrap();
    int unsigned n_pop;
    while (shadow_count < cnt_t'(Depth)) send_op(OpPush, rand_key());
    send_op(OpPush, rand_key());
    send_op(OpPush, '1);
    send_op(OpFind, shadow_keys[shadow_head]);
    send_op(OpFind, shadow_keys[idx_t'((shadow_tail + Depth - 1) % Depth)]);
    n_pop = $urandom_range(Depth / 4, Depth - 4);
    repeat (n_pop) send_op(OpPop, rand_key());
    while (shadow_count < cnt_t'(Depth)) send_op(OpPush, rand_key());
    send_op(OpFind, shadow_keys[idx_t'((shadow_tail + Depth - 1) % Depth)]);
    send_op(OpFind, key_t'({$urandom, $urandom}));
    send_op(OpPush, rand_key());
    while (shadow_count != '0) send_op(OpPop, rand_key());
    send_op(OpPop, rand_key());
    send_op(OpFind, rand_key());
  endtask

  // Bursts that push the occupancy up and down with random content
  task automatic test_random_mix(int unsigned n_items);
    int unsigned sent;
    int unsigned burst;
    mix_bias_e   bias;
    logic [OpW-1:0] op;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(0, 2))
        0:       bias = BiasFill;
        1:       bias = BiasDrain;
        default: bias = BiasMixed;
      endcase
      burst = $urandom_range(20, 80);
      repeat (burst) begin
        op = pick_op(bias);
        send_op(op, (op == OpFind) ? find_key() : rand_key());
        sent++;
      end
    end
  endtask

  initial begin
    mismatch_count  = 0;
    sender_idle_pct = 16;
    recv_stall_pct  = 68;
    shadow_head     = '0;
    shadow_tail     = '0;
    shadow_count    = '0;
    rst_ni        <= 1'b0;
    req_if.valid  <= 1'b0;
    req_if.opcode <= OpPush;
    req_if.key    <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    drain_results();
    test_fill_and_wrap();
    drain_results();
    test_random_mix(150);

    sender_idle_pct = 68;
    recv_stall_pct  = 16;
    test_random_mix(150);
    drain_results();

    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    test_fill_and_wrap();
    test_random_mix(100);

    drain_results();
    repeat (Depth + 8) @(posedge clk_i);
    if (mismatch_count == 0 && predicted_rsps.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Run limit
  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

/* files.f */
hw/rtl/fifoms_pkg.sv
hw/rtl/fifoms_if.sv
hw/rtl/fifoms_store.sv
hw/rtl/fifo_with_membership_search_top.sv
tb/sv/fifo_with_membership_search_top_test.sv
